@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the chunk dispenser.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define GCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define GCD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define GCD_ASSERT(lbl, prop, msg)

`define GCD_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ hw/rtl/gcd_pkg.sv @@
// Package of the guided chunk dispenser: request codes, widths and the microcode table.
// Depends on nothing; used by guided_chunk_dispenser.
`default_nettype none

package gcd_pkg;

  localparam int unsigned MaxThreads = 64;
  localparam int unsigned ThrW = 7;
  localparam int unsigned PcW = 5;

  localparam logic [ThrW-1:0] ThrCap =
    (MaxThreads > 127) ? 7'd127 : ThrW'(MaxThreads);

  localparam logic [1:0] OpBegin = 2'd0;
  localparam logic [1:0] OpNext  = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_CAPT,
    ACT_DIVS_INIT,
    ACT_DIV_ITER,
    ACT_FIRST,
    ACT_ENTER,
    ACT_DIVT_INIT,
    ACT_CS,
    ACT_MUL,
    ACT_COMMIT,
    ACT_CLAMP,
    ACT_CLEAR,
    ACT_RES_NONE,
    ACT_RES_WHOLE,
    ACT_EMIT,
    ACT_SPARE
  } act_e;

  typedef enum logic [3:0] {
    CND_ALWAYS,
    CND_NEVER,
    CND_NOACC,
    CND_NOTBEGIN,
    CND_STEPZERO,
    CND_DIVMORE,
    CND_TRIPBAD,
    CND_T1,
    CND_ENTERED,
    CND_REMZERO,
    CND_NOTNEXT,
    CND_NOCHUNK,
    CND_NOTCLEAR,
    CND_OUTBUSY
  } cond_e;

  typedef struct packed {
    act_e           act;
    cond_e          cnd;
    logic [PcW-1:0] tgt;
  } ctrl_word_t;

  localparam logic [PcW-1:0] PcIdle    = 5'd0;
  localparam logic [PcW-1:0] PcSDiv    = 5'd3;
  localparam logic [PcW-1:0] PcLater   = 5'd8;
  localparam logic [PcW-1:0] PcChunk   = 5'd9;
  localparam logic [PcW-1:0] PcTDiv    = 5'd10;
  localparam logic [PcW-1:0] PcNotBeg  = 5'd14;
  localparam logic [PcW-1:0] PcNotNext = 5'd17;
  localparam logic [PcW-1:0] PcNone    = 5'd19;
  localparam logic [PcW-1:0] PcWhole   = 5'd20;
  localparam logic [PcW-1:0] PcEmit    = 5'd21;

  // Control store: a taken condition jumps to the target, otherwise the step counter advances.
  function automatic ctrl_word_t ucode(input logic [PcW-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      5'd0:    w = '{act: ACT_CAPT,      cnd: CND_NOACC,    tgt: PcIdle};
      5'd1:    w = '{act: ACT_NOP,       cnd: CND_NOTBEGIN, tgt: PcNotBeg};
      5'd2:    w = '{act: ACT_DIVS_INIT, cnd: CND_STEPZERO, tgt: PcNone};
      5'd3:    w = '{act: ACT_DIV_ITER,  cnd: CND_DIVMORE,  tgt: PcSDiv};
      5'd4:    w = '{act: ACT_NOP,       cnd: CND_TRIPBAD,  tgt: PcNone};
      5'd5:    w = '{act: ACT_NOP,       cnd: CND_T1,       tgt: PcWhole};
      5'd6:    w = '{act: ACT_NOP,       cnd: CND_ENTERED,  tgt: PcLater};
      5'd7:    w = '{act: ACT_FIRST,     cnd: CND_ALWAYS,   tgt: PcChunk};
      5'd8:    w = '{act: ACT_ENTER,     cnd: CND_REMZERO,  tgt: PcNone};
      5'd9:    w = '{act: ACT_DIVT_INIT, cnd: CND_NEVER,    tgt: PcIdle};
      5'd10:   w = '{act: ACT_DIV_ITER,  cnd: CND_DIVMORE,  tgt: PcTDiv};
      5'd11:   w = '{act: ACT_CS,        cnd: CND_NEVER,    tgt: PcIdle};
      5'd12:   w = '{act: ACT_MUL,       cnd: CND_NEVER,    tgt: PcIdle};
      5'd13:   w = '{act: ACT_COMMIT,    cnd: CND_ALWAYS,   tgt: PcEmit};
      5'd14:   w = '{act: ACT_NOP,       cnd: CND_NOTNEXT,  tgt: PcNotNext};
      5'd15:   w = '{act: ACT_NOP,       cnd: CND_NOCHUNK,  tgt: PcNone};
      5'd16:   w = '{act: ACT_CLAMP,     cnd: CND_ALWAYS,   tgt: PcChunk};
      5'd17:   w = '{act: ACT_NOP,       cnd: CND_NOTCLEAR, tgt: PcNone};
      5'd18:   w = '{act: ACT_CLEAR,     cnd: CND_NEVER,    tgt: PcIdle};
      5'd19:   w = '{act: ACT_RES_NONE,  cnd: CND_ALWAYS,   tgt: PcEmit};
      5'd20:   w = '{act: ACT_RES_WHOLE, cnd: CND_NEVER,    tgt: PcIdle};
      5'd21:   w = '{act: ACT_EMIT,      cnd: CND_OUTBUSY,  tgt: PcEmit};
      5'd22:   w = '{act: ACT_NOP,       cnd: CND_ALWAYS,   tgt: PcIdle};
      default: w = '{act: ACT_NOP,       cnd: CND_ALWAYS,   tgt: PcIdle};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/guided_chunk_dispenser.sv @@
// Top level of the guided chunk dispenser: microcoded sequencer and its datapath.
// Depends on gcd_pkg and assert_macros.svh.
`default_nettype none

// Hands out chunks of a shared loop under a guided schedule, one request beat at a time.
// The sequencer uses the one shared restoring divider, which retires one quotient bit per
// cycle: a begin runs it once for the trip count and, when it goes on to hand out a chunk,
// once for the share per thread; a next that grants a chunk runs it once. A clear, an
// unknown request, a next with nothing left or a begin with a zero step do not run it. The
// emit step waits while the result register is held by out_stall_i before handing on.
// team_threads is to be written through the cfg channel only while no request is in flight;
// the block itself does not enforce this.
module guided_chunk_dispenser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] lower_bound_i,
  input  wire logic [31:0] upper_bound_i,
  input  wire logic [31:0] step_i,
  input  wire logic [30:0] min_chunk_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             granted_o,
  output logic [31:0]      chunk_from_o,
  output logic [31:0]      chunk_to_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [gcd_pkg::ThrW-1:0] cfg_team_threads_i
);

  logic [gcd_pkg::PcW-1:0]  pc_q, pc_d;
  logic [gcd_pkg::ThrW-1:0] threads_q, threads_d;
  logic [gcd_pkg::ThrW-1:0] entered_q, entered_d;
  logic [31:0]              rem_q, rem_d;
  logic [31:0]              next_idx_q, next_idx_d;
  logic [31:0]              loop_step_q, loop_step_d;
  logic [30:0]              loop_min_q, loop_min_d;
  logic                     out_valid_q, out_valid_d;

  logic [1:0]  op_q, op_d;
  logic [31:0] lb_q, lb_d;
  logic [31:0] ub_q, ub_d;
  logic [31:0] step_q, step_d;
  logic [30:0] min_q, min_d;
  logic [32:0] diff_q, diff_d;
  logic        clamp_q, clamp_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] cs_q, cs_d;
  logic [31:0] prod_q, prod_d;
  logic        res_gnt_q, res_gnt_d;
  logic [31:0] res_from_q, res_from_d;
  logic [31:0] res_to_q, res_to_d;
  logic        out_gnt_q, out_gnt_d;
  logic [31:0] out_from_q, out_from_d;
  logic [31:0] out_to_q, out_to_d;

  gcd_pkg::ctrl_word_t cw;
  logic                in_acc;
  logic                out_busy;
  logic                cond;
  logic [gcd_pkg::ThrW-1:0] eff_thr;
  logic [33:0]         trial;
  logic [32:0]         diff_neg;
  logic [31:0]         share;
  logic [31:0]         min_ext;
  logic [31:0]         idx_sum;

  assign cw          = gcd_pkg::ucode(pc_q);
  assign in_stall_o  = (pc_q != gcd_pkg::PcIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_busy    = out_valid_q && out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o  = out_valid_q;
  assign granted_o    = out_gnt_q;
  assign chunk_from_o = out_from_q;
  assign chunk_to_o   = out_to_q;

  always_comb begin
    if (threads_q == '0) begin
      eff_thr = gcd_pkg::ThrW'(1);
    end else if (threads_q > gcd_pkg::ThrCap) begin
      eff_thr = gcd_pkg::ThrCap;
    end else begin
      eff_thr = threads_q;
    end
  end

  assign trial    = {1'b0, acc_q, quo_q[31]} - {2'b00, dvs_q};
  assign diff_neg = '0 - diff_q;
  assign share    = quo_q + {31'd0, (acc_q != '0)};
  assign min_ext  = {1'b0, loop_min_q};
  assign idx_sum  = next_idx_q + prod_q;

  always_comb begin
    unique case (cw.cnd)
      gcd_pkg::CND_ALWAYS:   cond = 1'b1;
      gcd_pkg::CND_NEVER:    cond = 1'b0;
      gcd_pkg::CND_NOACC:    cond = !in_acc;
      gcd_pkg::CND_NOTBEGIN: cond = (op_q != gcd_pkg::OpBegin);
      gcd_pkg::CND_STEPZERO: cond = (step_q == '0);
      gcd_pkg::CND_DIVMORE:  cond = (cnt_q != 5'd31);
      gcd_pkg::CND_TRIPBAD:  cond = (quo_q == '0) || (diff_q[32] != step_q[31]);
      gcd_pkg::CND_T1:       cond = (eff_thr == gcd_pkg::ThrW'(1));
      gcd_pkg::CND_ENTERED:  cond = (entered_q != '0);
      gcd_pkg::CND_REMZERO:  cond = (rem_q == '0);
      gcd_pkg::CND_NOTNEXT:  cond = (op_q != gcd_pkg::OpNext);
      gcd_pkg::CND_NOCHUNK:  cond = (eff_thr == gcd_pkg::ThrW'(1)) || (rem_q == '0);
      gcd_pkg::CND_NOTCLEAR: cond = (op_q != gcd_pkg::OpClear);
      gcd_pkg::CND_OUTBUSY:  cond = out_busy;
      default:               cond = 1'b1;
    endcase
  end

  always_comb begin
    pc_d        = cond ? cw.tgt : pc_q + gcd_pkg::PcW'(1);
    threads_d   = (cfg_valid_i && cfg_ready_o) ? cfg_team_threads_i : threads_q;
    entered_d   = entered_q;
    rem_d       = rem_q;
    next_idx_d  = next_idx_q;
    loop_step_d = loop_step_q;
    loop_min_d  = loop_min_q;
    out_valid_d = out_valid_q && out_stall_i;
    op_d        = op_q;
    lb_d        = lb_q;
    ub_d        = ub_q;
    step_d      = step_q;
    min_d       = min_q;
    diff_d      = diff_q;
    clamp_d     = clamp_q;
    acc_d       = acc_q;
    quo_d       = quo_q;
    dvs_d       = dvs_q;
    cnt_d       = cnt_q;
    cs_d        = cs_q;
    prod_d      = prod_q;
    res_gnt_d   = res_gnt_q;
    res_from_d  = res_from_q;
    res_to_d    = res_to_q;
    out_gnt_d   = out_gnt_q;
    out_from_d  = out_from_q;
    out_to_d    = out_to_q;

    unique case (cw.act)
      gcd_pkg::ACT_CAPT: begin
        if (in_acc) begin
          op_d   = op_i;
          lb_d   = lower_bound_i;
          ub_d   = upper_bound_i;
          step_d = step_i;
          min_d  = min_chunk_i;
          diff_d = {upper_bound_i[31], upper_bound_i} - {lower_bound_i[31], lower_bound_i};
        end
      end
      gcd_pkg::ACT_DIVS_INIT: begin
        acc_d = '0;
        cnt_d = '0;
        quo_d = diff_q[32] ? diff_neg[31:0] : diff_q[31:0];
        dvs_d = step_q[31] ? ('0 - step_q) : step_q;
      end
      gcd_pkg::ACT_DIVT_INIT: begin
        acc_d = '0;
        cnt_d = '0;
        quo_d = rem_q;
        dvs_d = {{(32 - gcd_pkg::ThrW){1'b0}}, eff_thr};
      end
      gcd_pkg::ACT_DIV_ITER: begin
        cnt_d = cnt_q + 5'd1;
        if (!trial[33]) begin
          acc_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          acc_d = {acc_q[30:0], quo_q[31]};
          quo_d = {quo_q[30:0], 1'b0};
        end
      end
      gcd_pkg::ACT_FIRST: begin
        entered_d   = gcd_pkg::ThrW'(1);
        loop_step_d = step_q;
        loop_min_d  = min_q;
        rem_d       = quo_q;
        next_idx_d  = lb_q;
        clamp_d     = 1'b0;
      end
      gcd_pkg::ACT_ENTER: begin
        if (entered_q != '1) begin
          entered_d = entered_q + gcd_pkg::ThrW'(1);
        end
        clamp_d = 1'b1;
      end
      gcd_pkg::ACT_CLAMP: begin
        clamp_d = 1'b1;
      end
      gcd_pkg::ACT_CS: begin
        if (clamp_q && (share < min_ext)) begin
          cs_d = (rem_q < min_ext) ? rem_q : min_ext;
        end else begin
          cs_d = share;
        end
      end
      gcd_pkg::ACT_MUL: begin
        prod_d = 32'(cs_q * loop_step_q);
      end
      gcd_pkg::ACT_COMMIT: begin
        rem_d      = rem_q - cs_q;
        next_idx_d = idx_sum;
        res_gnt_d  = 1'b1;
        res_from_d = next_idx_q;
        res_to_d   = idx_sum;
      end
      gcd_pkg::ACT_CLEAR: begin
        entered_d = '0;
        rem_d     = '0;
      end
      gcd_pkg::ACT_RES_NONE: begin
        res_gnt_d  = 1'b0;
        res_from_d = '0;
        res_to_d   = '0;
      end
      gcd_pkg::ACT_RES_WHOLE: begin
        res_gnt_d  = 1'b1;
        res_from_d = lb_q;
        res_to_d   = ub_q;
      end
      gcd_pkg::ACT_EMIT: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          out_gnt_d   = res_gnt_q;
          out_from_d  = res_from_q;
          out_to_d    = res_to_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= gcd_pkg::PcIdle;
      threads_q   <= gcd_pkg::ThrW'(1);
      entered_q   <= '0;
      rem_q       <= '0;
      next_idx_q  <= '0;
      loop_step_q <= '0;
      loop_min_q  <= 31'd1;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      threads_q   <= threads_d;
      entered_q   <= entered_d;
      rem_q       <= rem_d;
      next_idx_q  <= next_idx_d;
      loop_step_q <= loop_step_d;
      loop_min_q  <= loop_min_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    lb_q       <= lb_d;
    ub_q       <= ub_d;
    step_q     <= step_d;
    min_q      <= min_d;
    diff_q     <= diff_d;
    clamp_q    <= clamp_d;
    acc_q      <= acc_d;
    quo_q      <= quo_d;
    dvs_q      <= dvs_d;
    cnt_q      <= cnt_d;
    cs_q       <= cs_d;
    prod_q     <= prod_d;
    res_gnt_q  <= res_gnt_d;
    res_from_q <= res_from_d;
    res_to_q   <= res_to_d;
    out_gnt_q  <= out_gnt_d;
    out_from_q <= out_from_d;
    out_to_q   <= out_to_d;
  end

`include "assert_macros.svh"

  // An accepted beat always starts the sequencer, so no second beat slips in behind it.
  `GCD_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "beat not taken up")
  // A refused request carries zero indices.
  `GCD_ASSERT(a_empty_zero, out_valid_o && !granted_o |-> chunk_from_o == '0 && chunk_to_o == '0, "empty result has indices")
  // Iterations remain only inside a loop that some thread has entered.
  `GCD_ASSERT_NEVER(a_rem_outside_loop, entered_q == '0 && rem_q != '0, "remainder without loop")

endmodule

`default_nettype wire
